>>> rtl/ssr_pkg.sv
// ----------------------------------------------------------------------------
// ssr_pkg
// Types, constants and helper functions shared by the servo slew ramp
// controller and its submodules.
// ----------------------------------------------------------------------------
package ssr_pkg;

  // Field widths.
  localparam int unsigned OpW    = 2;
  localparam int unsigned ChanW  = 2;
  localparam int unsigned PctW   = 8;
  localparam int unsigned PwmW   = 10;
  localparam int unsigned GapW   = 15;

  // Packed widths on the stream ports.
  localparam int unsigned InDataW  = 16;
  localparam int unsigned InUserW  = 4;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned OutUserW = 2;

  // Reset value of the ramp step gap.
  localparam logic [GapW-1:0] GapReset = 15'd10;

  // Largest valid percent position.
  localparam logic [PctW-1:0] PctMax = 8'd100;

  // Compare value at zero percent and at the center position.
  localparam logic [PwmW-1:0] PwmBase   = 10'd120;
  localparam logic [PwmW-1:0] PwmCenter = 10'd360;

  // Reciprocal of five in 16 fraction bits; exact for products up to 6120.
  localparam logic [13:0] RecipFive = 14'd13108;

  // Command codes.
  typedef enum logic [OpW-1:0] {
    OP_TICK   = 2'd0,
    OP_SET    = 2'd1,
    OP_MOVE   = 2'd2,
    OP_CENTER = 2'd3
  } op_e;

  // Channel selection for an immediate set.
  typedef enum logic [ChanW-1:0] {
    CH_LEFT  = 2'd0,
    CH_RIGHT = 2'd1,
    CH_AUX   = 2'd2,
    CH_NONE  = 2'd3
  } chan_e;

  // One registered command on its way to the update logic.
  typedef struct packed {
    op_e             op;
    chan_e           channel;
    logic [PctW-1:0] pos_a;
    logic [PctW-1:0] pos_b;
  } cmd_t;

  // Converts a percent position to a compare value: 120 + floor(p*24/5).
  function automatic logic [PwmW-1:0] pct_to_pwm(input logic [PctW-1:0] p);
    logic [12:0] prod;
    logic [26:0] scaled;
    logic [PwmW-1:0] quot;
    prod   = {1'b0, p, 4'b0000} + {2'b00, p, 3'b000};
    scaled = {14'd0, prod} * {13'd0, RecipFive};
    quot   = scaled[25:16];
    return PwmBase + quot;
  endfunction

  // Moves a current value one count toward its target.
  function automatic logic [PwmW-1:0] slew_one(input logic [PwmW-1:0] cur,
                                               input logic [PwmW-1:0] tgt);
    logic [PwmW-1:0] res;
    if (cur < tgt) begin
      res = cur + 10'd1;
    end else if (cur > tgt) begin
      res = cur - 10'd1;
    end else begin
      res = cur;
    end
    return res;
  endfunction

endpackage

>>> rtl/ssr_in_stage.sv
// ----------------------------------------------------------------------------
// ssr_in_stage
// Input register: captures one command beat and holds it until the update
// stage takes it. A new beat is taken in the same cycle the held one leaves.
// ----------------------------------------------------------------------------
module ssr_in_stage
  import ssr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic [InUserW-1:0]  s_axis_tuser,
  output logic                cmd_valid_o,
  output cmd_t                cmd_o,
  input  logic                cmd_ready_i
);

  logic valid_q, valid_d;
  cmd_t cmd_q;

  // Ready whenever the register is empty or is being drained this cycle.
  assign s_axis_tready = !valid_q || cmd_ready_i;

  // Valid flag follows the handshakes on both sides.
  always_comb begin
    valid_d = valid_q;
    if (s_axis_tready) begin
      valid_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload capture; no reset needed.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      cmd_q.op      <= op_e'(s_axis_tuser[1:0]);
      cmd_q.channel <= chan_e'(s_axis_tuser[3:2]);
      cmd_q.pos_a   <= s_axis_tdata[7:0];
      cmd_q.pos_b   <= s_axis_tdata[15:8];
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

>>> rtl/ssr_core.sv
// ----------------------------------------------------------------------------
// ssr_core
// Servo state and update logic. Applies one registered command per cycle while
// the result register is free or draining, and writes the servo values there.
// ----------------------------------------------------------------------------
module ssr_core
  import ssr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [GapW-1:0]     cfg_wdata_i,
  input  logic                cmd_valid_i,
  input  cmd_t                cmd_i,
  output logic                cmd_ready_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic [OutUserW-1:0] m_axis_tuser
);

  logic [GapW-1:0] gap_q;
  logic [PwmW-1:0] left_cur_q, left_cur_d, right_cur_q, right_cur_d;
  logic [PwmW-1:0] left_tgt_q, left_tgt_d, right_tgt_q, right_tgt_d;
  logic [PwmW-1:0] aux_q, aux_d;
  logic            left_vld_q, left_vld_d, right_vld_q, right_vld_d;
  logic            ramp_q, ramp_d;
  logic [GapW-1:0] tick_q, tick_d;
  logic            acc_d;
  logic            out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic [OutUserW-1:0] out_user_q;
  logic            advance;
  logic [PwmW-1:0] pwm_a, pwm_b;
  logic            a_ok, b_ok;

  // A command moves on when the result register is free or draining.
  assign cmd_ready_o = !out_valid_q || m_axis_tready;
  assign advance     = cmd_valid_i && cmd_ready_o;

  // Percent conversions and range checks.
  assign pwm_a = pct_to_pwm(cmd_i.pos_a);
  assign pwm_b = pct_to_pwm(cmd_i.pos_b);
  assign a_ok  = cmd_i.pos_a <= PctMax;
  assign b_ok  = cmd_i.pos_b <= PctMax;

  // Next state for one command.
  always_comb begin
    left_cur_d  = left_cur_q;
    right_cur_d = right_cur_q;
    left_tgt_d  = left_tgt_q;
    right_tgt_d = right_tgt_q;
    aux_d       = aux_q;
    left_vld_d  = left_vld_q;
    right_vld_d = right_vld_q;
    ramp_d      = ramp_q;
    tick_d      = tick_q;
    acc_d       = 1'b0;
    case (cmd_i.op)
      OP_TICK: begin
        if (ramp_q) begin
          acc_d = 1'b1;
          if (tick_q < gap_q) begin
            tick_d = tick_q + 15'd1;
          end else begin
            tick_d      = '0;
            left_cur_d  = slew_one(left_cur_q, left_tgt_q);
            right_cur_d = slew_one(right_cur_q, right_tgt_q);
          end
        end
      end
      OP_SET: begin
        if (a_ok) begin
          case (cmd_i.channel)
            CH_LEFT: begin
              ramp_d     = 1'b0;
              left_cur_d = pwm_a;
              left_vld_d = 1'b1;
              acc_d      = 1'b1;
            end
            CH_RIGHT: begin
              ramp_d      = 1'b0;
              right_cur_d = pwm_a;
              right_vld_d = 1'b1;
              acc_d       = 1'b1;
            end
            CH_AUX: begin
              aux_d = pwm_a;
              acc_d = 1'b1;
            end
            default: begin
              acc_d = 1'b0;
            end
          endcase
        end
      end
      OP_MOVE: begin
        if (a_ok && b_ok && left_vld_q && right_vld_q) begin
          left_tgt_d  = pwm_a;
          right_tgt_d = pwm_b;
          ramp_d      = 1'b1;
          acc_d       = 1'b1;
        end
      end
      default: begin
        left_cur_d  = PwmCenter;
        right_cur_d = PwmCenter;
        left_vld_d  = 1'b1;
        right_vld_d = 1'b1;
        acc_d       = 1'b1;
      end
    endcase
  end

  // Servo state and ramp gap register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q       <= GapReset;
      left_cur_q  <= '0;
      right_cur_q <= '0;
      left_tgt_q  <= '0;
      right_tgt_q <= '0;
      aux_q       <= '0;
      left_vld_q  <= 1'b0;
      right_vld_q <= 1'b0;
      ramp_q      <= 1'b0;
      tick_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        gap_q <= cfg_wdata_i;
      end
      if (advance) begin
        left_cur_q  <= left_cur_d;
        right_cur_q <= right_cur_d;
        left_tgt_q  <= left_tgt_d;
        right_tgt_q <= right_tgt_d;
        aux_q       <= aux_d;
        left_vld_q  <= left_vld_d;
        right_vld_q <= right_vld_d;
        ramp_q      <= ramp_d;
        tick_q      <= tick_d;
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_ready_o) begin
      out_valid_q <= cmd_valid_i;
    end
  end

  // Result payload, taken after the update.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {2'b00, aux_d, right_cur_d, left_cur_d};
      out_user_q <= {acc_d, ramp_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

>>> rtl/servo_slew_ramp_controller.sv
// ----------------------------------------------------------------------------
// servo_slew_ramp_controller
// Two servo channels that ramp their compare value one count per prescaled
// tick toward a target, plus an auxiliary channel that is only set at once.
//
//   Channel   Direction  Beat contents
//   s_axis    in         one command: op, channel, two percent positions
//   m_axis    out        one result per command: three compare values, flags
//   cfg       in         ramp step gap in ticks, minus one
//
// Each command passes through the input register and then the update stage,
// which writes the result register. One command is accepted per cycle while
// the result side keeps up; a stalled result holds the update stage, and the
// input register then fills and drops ready.
// Reset clears all servo state and sets the step gap to ten.
// ----------------------------------------------------------------------------
module servo_slew_ramp_controller
  import ssr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write of the ramp step gap.
  input  logic                cfg_we_i,
  input  logic [GapW-1:0]     cfg_wdata_i,
  // Command stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // pos_a[7:0], pos_b[15:8]
  input  logic [InUserW-1:0]  s_axis_tuser,   // op[1:0], channel[3:2]
  // Result stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // left_pwm[9:0], right_pwm[19:10],
                                              // aux_pwm[29:20], zeros[31:30]
  output logic [OutUserW-1:0] m_axis_tuser    // ramp_active[0], accepted[1]
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Command input register.
  ssr_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_ready_i   (cmd_ready)
  );

  // State update and result register.
  ssr_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_ready_o   (cmd_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
